### rtl/aesmo_pkg.sv
// Shared types, constants and AES round functions for the mode-of-operation encryptor.
package aesmo_pkg;

	// Mode register codes
	localparam logic [2:0] MODE_ECB = 3'd0;
	localparam logic [2:0] MODE_CBC = 3'd1;
	localparam logic [2:0] MODE_CFB = 3'd2;
	localparam logic [2:0] MODE_OFB = 3'd3;
	localparam logic [2:0] MODE_CTR = 3'd4;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_KEY_WORDS = 3'd1;
	localparam logic [2:0] REG_KEY_0     = 3'd2;
	localparam logic [2:0] REG_KEY_1     = 3'd3;
	localparam logic [2:0] REG_KEY_2     = 3'd4;
	localparam logic [2:0] REG_KEY_3     = 3'd5;
	localparam logic [2:0] REG_IV_HIGH   = 3'd6;
	localparam logic [2:0] REG_IV_LOW    = 3'd7;

	// Key schedule counters: at most 60 words, 15 rows of four words
	localparam int KW_IDX_W = 6;
	localparam int RK_ROW_W = 4;
	localparam int RND_W    = 4;

	// Controller to datapath commands
	typedef struct packed {
		logic                capture;
		logic                msg_init;
		logic                exp_en;
		logic [KW_IDX_W-1:0] exp_idx;
		logic [2:0]          exp_phase;
		logic                rk_rd;
		logic [RK_ROW_W-1:0] rk_row;
		logic                ark0;
		logic                round;
		logic                last_round;
		logic                finish;
		logic                hdr;
	} aesmo_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic             mode_bad;
		logic             ecb;
		logic             last;
		logic [3:0]       nk;
		logic [RND_W-1:0] rounds;
	} aesmo_stat_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic logic [7:0] sbox(input logic [7:0] x);
		return SBOX[x];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// One cipher round on a 128-bit state, byte 0 in the top bits
	function automatic logic [127:0] aes_round(input logic [127:0] st, input logic [127:0] rk,
			input logic final_rnd);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] m [16];
		logic [127:0] res;
		for (int b = 0; b < 16; b++) s[b] = sbox(st[127-8*b -: 8]);
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[r+4*c] = s[r + 4*((c+r) % 4)];
		for (int c = 0; c < 4; c++) begin
			m[4*c]   = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
			m[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
			m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
			m[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
		end
		for (int b = 0; b < 16; b++) res[127-8*b -: 8] = final_rnd ? t[b] : m[b];
		return res ^ rk;
	endfunction

endpackage

### rtl/aes_mode_of_operation_encryptor.sv
// Top level: configuration registers, controller and datapath of the AES mode encryptor.
// Sequence: the first block of a message runs the key schedule of 4*(Nr+1) words, then the IV
//   header (modes other than ECB), then the round-key load and the rounds; later blocks go
//   straight to the round-key load and the rounds (Nr = 10, 12 or 14).
// Each block runs on the single shared round unit; a new block is taken only once the previous result is accepted.
// Reset: asynchronous, clears the controller and the configuration registers.
module aes_mode_of_operation_encryptor import aesmo_pkg::*; #(
	parameter int ROUND_KEY_WORDS = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	input  logic [4:0]  byte_count,
	input  logic        message_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] out_high,
	output logic [63:0] out_low,
	output logic [4:0]  out_bytes,
	output logic        is_iv_header,
	output logic        run_end,
	output logic        message_end
);

	logic [2:0]  mode_q;
	logic [3:0]  key_words_q;
	logic [63:0] key_0_q, key_1_q, key_2_q, key_3_q, iv_high_q, iv_low_q;
	logic        wr_en;
	logic [2:0]  reg_idx;

	aesmo_cmd_t  cmd;
	aesmo_stat_t stat;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[5:3];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_ECB;
			key_words_q <= 4'd4;
			key_0_q     <= '0;
			key_1_q     <= '0;
			key_2_q     <= '0;
			key_3_q     <= '0;
			iv_high_q   <= '0;
			iv_low_q    <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MODE:      mode_q      <= pwdata[2:0];
				REG_KEY_WORDS: key_words_q <= pwdata[3:0];
				REG_KEY_0:     key_0_q     <= pwdata;
				REG_KEY_1:     key_1_q     <= pwdata;
				REG_KEY_2:     key_2_q     <= pwdata;
				REG_KEY_3:     key_3_q     <= pwdata;
				REG_IV_HIGH:   iv_high_q   <= pwdata;
				REG_IV_LOW:    iv_low_q    <= pwdata;
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (reg_idx)
			REG_MODE:      prdata = {61'h0, mode_q};
			REG_KEY_WORDS: prdata = {60'h0, key_words_q};
			REG_KEY_0:     prdata = key_0_q;
			REG_KEY_1:     prdata = key_1_q;
			REG_KEY_2:     prdata = key_2_q;
			REG_KEY_3:     prdata = key_3_q;
			REG_IV_HIGH:   prdata = iv_high_q;
			REG_IV_LOW:    prdata = iv_low_q;
			default:       prdata = '0;
		endcase
	end

	aesmo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	aesmo_dp #(
		.ROUND_KEY_WORDS(ROUND_KEY_WORDS)
	) u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_mode     (mode_q),
		.cfg_key_words(key_words_q),
		.cfg_key_0    (key_0_q),
		.cfg_key_1    (key_1_q),
		.cfg_key_2    (key_2_q),
		.cfg_key_3    (key_3_q),
		.cfg_iv_high  (iv_high_q),
		.cfg_iv_low   (iv_low_q),
		.block_high   (block_high),
		.block_low    (block_low),
		.byte_count   (byte_count),
		.message_last (message_last),
		.out_high     (out_high),
		.out_low      (out_low),
		.out_bytes    (out_bytes),
		.is_iv_header (is_iv_header),
		.run_end      (run_end),
		.message_end  (message_end)
	);

	// The block only takes a new transaction when no result is pending
	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("input taken while a result is pending");

	// Header is a full block and never the last result of an input
	a_hdr_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_iv_header |-> !run_end && !message_end && out_bytes == 5'd16)
		else $error("malformed IV header");

	// Message end only on the ciphertext result of an input
	a_mend_rend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_end |-> run_end)
		else $error("message end without run end");

	// Byte count never exceeds a block
	a_bytes_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_bytes <= 5'd16)
		else $error("result byte count out of range");

endmodule

### rtl/aesmo_ram.sv
// Generic single-port-write, registered-read RAM.
module aesmo_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 15
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

### rtl/aesmo_ctrl.sv
// Sequencer for key expansion, header emission and the iterative cipher rounds.
module aesmo_ctrl import aesmo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  aesmo_stat_t stat,
	output aesmo_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXP  = 6'b000010,
		S_HDR  = 6'b000100,
		S_LOAD = 6'b001000,
		S_RND  = 6'b010000,
		S_RES  = 6'b100000
	} state_t;

	state_t              state_q, state_d;
	logic                started_q;
	logic [KW_IDX_W-1:0] idx_q;
	logic [2:0]          phase_q;
	logic [RND_W-1:0]    rnd_q;
	logic [KW_IDX_W-1:0] total;

	// Key words in the schedule: 4 * (rounds + 1)
	assign total = {stat.rounds + 4'd1, 2'b00};

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_HDR) || (state_q == S_RES);

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.exp_idx   = idx_q;
		cmd.exp_phase = phase_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !stat.mode_bad) begin
					cmd.capture = 1'b1;
					if (!started_q) begin
						cmd.msg_init = 1'b1;
						state_d      = S_EXP;
					end else begin
						state_d = S_LOAD;
					end
				end
			end
			S_EXP: begin
				cmd.exp_en = 1'b1;
				if (idx_q == total - 6'd1) begin
					if (stat.ecb) begin
						state_d = S_LOAD;
					end else begin
						cmd.hdr = 1'b1;
						state_d = S_HDR;
					end
				end
			end
			S_HDR: begin
				if (!out_stall) state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.rk_rd  = 1'b1;
				cmd.rk_row = '0;
				state_d    = S_RND;
			end
			S_RND: begin
				cmd.rk_row = rnd_q + 4'd1;
				if (rnd_q == '0) cmd.ark0 = 1'b1;
				else cmd.round = 1'b1;
				if (rnd_q == stat.rounds) begin
					cmd.last_round = 1'b1;
					cmd.finish     = 1'b1;
					state_d        = S_RES;
				end else begin
					cmd.rk_rd = 1'b1;
				end
			end
			S_RES: begin
				if (!out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			started_q <= 1'b0;
			idx_q     <= '0;
			phase_q   <= '0;
			rnd_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.msg_init) started_q <= 1'b1;
			else if (cmd.finish && stat.last) started_q <= 1'b0;
			if (cmd.msg_init) begin
				idx_q   <= '0;
				phase_q <= '0;
			end else if (cmd.exp_en) begin
				idx_q   <= idx_q + 6'd1;
				phase_q <= (phase_q == 3'(stat.nk - 4'd1)) ? 3'd0 : phase_q + 3'd1;
			end
			if (state_q == S_LOAD) rnd_q <= '0;
			else if (state_q == S_RND) rnd_q <= rnd_q + 4'd1;
		end
	end

endmodule

### rtl/aesmo_dp.sv
// Datapath: key schedule, round-key memory, cipher state, chaining and result registers.
module aesmo_dp import aesmo_pkg::*; #(
	parameter int ROUND_KEY_WORDS = 60
) (
	input  logic        clk,
	input  aesmo_cmd_t  cmd,
	output aesmo_stat_t stat,
	input  logic [2:0]  cfg_mode,
	input  logic [3:0]  cfg_key_words,
	input  logic [63:0] cfg_key_0,
	input  logic [63:0] cfg_key_1,
	input  logic [63:0] cfg_key_2,
	input  logic [63:0] cfg_key_3,
	input  logic [63:0] cfg_iv_high,
	input  logic [63:0] cfg_iv_low,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	input  logic [4:0]  byte_count,
	input  logic        message_last,
	output logic [63:0] out_high,
	output logic [63:0] out_low,
	output logic [4:0]  out_bytes,
	output logic        is_iv_header,
	output logic        run_end,
	output logic        message_end
);

	localparam int  RK_ROWS = ROUND_KEY_WORDS / 4;
	localparam int  AW      = $clog2(RK_ROWS);
	localparam bit  FIT8    = (ROUND_KEY_WORDS >= 60);
	localparam bit  FIT6    = (ROUND_KEY_WORDS >= 52);

	logic [127:0] p_q, chain_q, st_q, res_q;
	logic [63:0]  ctr_q;
	logic [4:0]   cnt_q, bytes_q;
	logic         last_q, hdr_q, rend_q, mend_q;
	logic [2:0]   mode_q;
	logic [3:0]   nk_q;
	logic [3:0]   nk_sel;
	logic [7:0]   rcon_q;
	logic [31:0]  win_q [8];
	logic [95:0]  row_acc_q;
	logic [127:0] rk_rdata;

	// Key length selection, shortened to what the schedule memory holds
	always_comb begin
		nk_sel = 4'd4;
		if (cfg_key_words == 4'd6) nk_sel = 4'd6;
		if (cfg_key_words == 4'd8) nk_sel = 4'd8;
		if (nk_sel == 4'd8 && !FIT8) nk_sel = 4'd6;
		if (nk_sel == 4'd6 && !FIT6) nk_sel = 4'd4;
	end

	assign stat.mode_bad = (cfg_mode > MODE_CTR);
	assign stat.ecb      = (mode_q == MODE_ECB);
	assign stat.last     = last_q;
	assign stat.nk       = nk_q;
	assign stat.rounds   = nk_q + 4'd6;

	// Key expansion: one schedule word per cycle
	logic [255:0] key_all;
	logic [31:0]  kwords [8];
	logic [31:0]  kw_t, kw_sub_in, kw_sub, kw_new;
	logic         from_key, rot_step;

	assign key_all  = {cfg_key_0, cfg_key_1, cfg_key_2, cfg_key_3};
	assign from_key = (cmd.exp_idx < {2'b00, nk_q});
	assign rot_step = (cmd.exp_phase == 3'd0);

	always_comb begin
		for (int k = 0; k < 8; k++) kwords[k] = key_all[255-32*k -: 32];
		kw_sub_in = rot_step ? {win_q[0][23:0], win_q[0][31:24]} : win_q[0];
		kw_sub    = sub_word(kw_sub_in);
		if (rot_step) kw_t = kw_sub ^ {rcon_q, 24'h0};
		else if (nk_q == 4'd8 && cmd.exp_phase == 3'd4) kw_t = kw_sub;
		else kw_t = win_q[0];
		if (from_key) kw_new = kwords[cmd.exp_idx[2:0]];
		else kw_new = win_q[3'(nk_q - 4'd1)] ^ kw_t;
	end

	always_ff @(posedge clk) begin
		if (cmd.msg_init) begin
			nk_q   <= nk_sel;
			rcon_q <= 8'h01;
		end else if (cmd.exp_en) begin
			win_q[0] <= kw_new;
			for (int k = 1; k < 8; k++) win_q[k] <= win_q[k-1];
			row_acc_q <= {row_acc_q[63:0], kw_new};
			if (!from_key && rot_step) rcon_q <= xtime(rcon_q);
		end
	end

	// Round keys, four words per row
	aesmo_ram #(
		.WIDTH(128),
		.DEPTH(RK_ROWS)
	) u_rk_ram (
		.clk  (clk),
		.we   (cmd.exp_en && (cmd.exp_idx[1:0] == 2'd3)),
		.waddr(cmd.exp_idx[AW+1:2]),
		.wdata({row_acc_q, kw_new}),
		.re   (cmd.rk_rd),
		.raddr(cmd.rk_row[AW-1:0]),
		.rdata(rk_rdata)
	);

	// Cipher input per mode
	logic [63:0]  ctr_swap;
	logic [127:0] ain, rnd_out, ks_p, ctr_mask, res_d, chain_d;
	logic [4:0]   cnt_sat, bytes_d;

	always_comb begin
		for (int b = 0; b < 8; b++) ctr_swap[63-8*b -: 8] = ctr_q[8*b +: 8];
		case (mode_q)
			MODE_CBC: ain = p_q ^ chain_q;
			MODE_CFB, MODE_OFB: ain = chain_q;
			MODE_CTR: ain = {chain_q[127:64], ctr_swap};
			default: ain = p_q;
		endcase
	end

	assign rnd_out = aes_round(st_q, rk_rdata, cmd.last_round);
	assign ks_p    = rnd_out ^ p_q;
	assign cnt_sat = (cnt_q > 5'd16) ? 5'd16 : cnt_q;

	// Final combination with chaining and partial-block mask
	always_comb begin
		for (int b = 0; b < 16; b++)
			ctr_mask[127-8*b -: 8] = (5'(b) < cnt_sat) ? 8'hff : 8'h00;
		res_d   = rnd_out;
		chain_d = chain_q;
		bytes_d = 5'd16;
		case (mode_q)
			MODE_CBC: chain_d = rnd_out;
			MODE_CFB: begin
				res_d   = ks_p;
				chain_d = ks_p;
			end
			MODE_OFB: begin
				res_d   = ks_p;
				chain_d = rnd_out;
			end
			MODE_CTR: begin
				res_d   = ks_p & ctr_mask;
				bytes_d = cnt_sat;
			end
			default: res_d = rnd_out;
		endcase
	end

	// Transaction capture, cipher state and results
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			p_q    <= {block_high, block_low};
			cnt_q  <= byte_count;
			last_q <= message_last;
			mode_q <= cfg_mode;
		end
		if (cmd.msg_init) begin
			chain_q <= {cfg_iv_high, (cfg_mode == MODE_CTR) ? 64'h0 : cfg_iv_low};
			ctr_q   <= '0;
		end else if (cmd.finish) begin
			chain_q <= chain_d;
			if (mode_q == MODE_CTR) ctr_q <= ctr_q + 64'd1;
		end
		if (cmd.ark0) st_q <= ain ^ rk_rdata;
		else if (cmd.round) st_q <= rnd_out;
		if (cmd.hdr) begin
			res_q   <= chain_q;
			bytes_q <= 5'd16;
			hdr_q   <= 1'b1;
			rend_q  <= 1'b0;
			mend_q  <= 1'b0;
		end else if (cmd.finish) begin
			res_q   <= res_d;
			bytes_q <= bytes_d;
			hdr_q   <= 1'b0;
			rend_q  <= 1'b1;
			mend_q  <= last_q;
		end
	end

	assign out_high     = res_q[127:64];
	assign out_low      = res_q[63:0];
	assign out_bytes    = bytes_q;
	assign is_iv_header = hdr_q;
	assign run_end      = rend_q;
	assign message_end  = mend_q;

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the AES mode-of-operation encryptor.
`timescale 1ns / 100ps

module tb import aesmo_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 100;
	localparam int HOLD_CYCLES    = 400;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic [4:0]  nbytes;
		logic        hdr;
		logic        rend;
		logic        mend;
	} ct_block_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic [63:0] block_high, block_low;
	logic [4:0]  byte_count;
	logic        message_last;
	logic        out_valid, out_stall;
	logic [63:0] out_high, out_low;
	logic [4:0]  out_bytes;
	logic        is_iv_header, run_end, message_end;

	aes_mode_of_operation_encryptor dut (.*);

	// Predictor state and register copies
	logic [2:0]  reg_mode;
	logic [3:0]  reg_key_words;
	logic [63:0] reg_key [4];
	logic [63:0] reg_iv_high, reg_iv_low;
	logic [63:0] chain [2];
	logic [63:0] blk_ctr;
	logic [31:0] sched [60];
	logic        msg_open;
	int          n_rounds;
	logic [7:0]  sub_tab [256];

	ct_block_t   pending_ct [$];
	int          fail_cnt = 0;
	int          idle_pct;
	int          hold_reqs;
	int          hold_done;
	int          hold_left;
	int          quiet_cycles;

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[0]) r ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
			b = b >> 1;
		end
		return r;
	endfunction

	function automatic logic [7:0] rol8(input logic [7:0] v, input int s);
		return (v << s) | (v >> (8 - s));
	endfunction

	// S-box from the field inverse and the affine map
	task automatic build_sub_tab();
		logic [7:0] r, base;
		int e;
		for (int x = 0; x < 256; x++) begin
			r = 8'h01;
			base = x[7:0];
			e = 254;
			while (e != 0) begin
				if (e & 1) r = gmul(r, base);
				base = gmul(base, base);
				e = e >> 1;
			end
			sub_tab[x] = r ^ rol8(r, 1) ^ rol8(r, 2) ^ rol8(r, 3) ^ rol8(r, 4) ^ 8'h63;
		end
	endtask

	function automatic logic [31:0] subw(input logic [31:0] w);
		return {sub_tab[w[31:24]], sub_tab[w[23:16]], sub_tab[w[15:8]], sub_tab[w[7:0]]};
	endfunction

	// Key schedule latched at message start
	task automatic expand_schedule();
		int nk, total;
		logic [7:0] rc;
		logic [31:0] t;
		nk = 4;
		if (reg_key_words == 4'd6) nk = 6;
		if (reg_key_words == 4'd8) nk = 8;
		rc = 8'h01;
		n_rounds = nk + 6;
		total = 4 * (n_rounds + 1);
		for (int i = 0; i < nk; i++)
			sched[i] = (i & 1) ? reg_key[i >> 1][31:0] : reg_key[i >> 1][63:32];
		for (int i = nk; i < total; i++) begin
			t = sched[i-1];
			if (i % nk == 0) begin
				t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = gmul(rc, 8'h02);
			end else if (nk > 6 && i % nk == 4) begin
				t = subw(t);
			end
			sched[i] = sched[i-nk] ^ t;
		end
	endtask

	function automatic logic [127:0] encrypt(input logic [127:0] pt);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3;
		logic [127:0] res;
		for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8];
		for (int rnd = 0; rnd <= n_rounds; rnd++) begin
			if (rnd > 0) begin
				for (int i = 0; i < 16; i++) s[i] = sub_tab[s[i]];
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						t[r+4*c] = s[r + 4*((c+r) & 3)];
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					if (rnd != n_rounds) begin
						s[4*c]   = gmul(a0, 2) ^ gmul(a1, 3) ^ a2 ^ a3;
						s[4*c+1] = a0 ^ gmul(a1, 2) ^ gmul(a2, 3) ^ a3;
						s[4*c+2] = a0 ^ a1 ^ gmul(a2, 2) ^ gmul(a3, 3);
						s[4*c+3] = gmul(a0, 3) ^ a1 ^ a2 ^ gmul(a3, 2);
					end else begin
						s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
					end
				end
			end
			// add round key
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					s[r+4*c] ^= sched[(4*rnd + c) % 60][31-8*r -: 8];
		end
		for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
		return res;
	endfunction

	function automatic logic [63:0] lead_bytes(input int k);
		if (k <= 0) return 64'h0;
		if (k >= 8) return '1;
		return ~64'h0 << (64 - 8*k);
	endfunction

	// Expected ciphertext for one accepted plaintext block
	task automatic predict_cipher(input logic [63:0] ph, input logic [63:0] pl,
			input logic [4:0] cnt_in, input logic last);
		logic [127:0] ks;
		logic [63:0] ch, cl, sw;
		int cnt;
		ct_block_t e;
		cnt = cnt_in;
		if (reg_mode > MODE_CTR) return;
		if (!msg_open) begin
			expand_schedule();
			blk_ctr = 64'h0;
			chain[0] = reg_iv_high;
			chain[1] = (reg_mode == MODE_CTR) ? 64'h0 : reg_iv_low;
			if (reg_mode != MODE_ECB) begin
				e = '{hi: chain[0], lo: chain[1], nbytes: 5'd16, hdr: 1'b1,
					rend: 1'b0, mend: 1'b0};
				pending_ct.push_back(e);
			end
			msg_open = 1'b1;
		end
		e.nbytes = 5'd16;
		case (reg_mode)
			MODE_ECB: begin
				{ch, cl} = encrypt({ph, pl});
			end
			MODE_CBC: begin
				{ch, cl} = encrypt({ph ^ chain[0], pl ^ chain[1]});
				chain[0] = ch; chain[1] = cl;
			end
			MODE_CFB: begin
				ks = encrypt({chain[0], chain[1]});
				ch = ks[127:64] ^ ph; cl = ks[63:0] ^ pl;
				chain[0] = ch; chain[1] = cl;
			end
			MODE_OFB: begin
				ks = encrypt({chain[0], chain[1]});
				chain[0] = ks[127:64]; chain[1] = ks[63:0];
				ch = ks[127:64] ^ ph; cl = ks[63:0] ^ pl;
			end
			default: begin
				for (int i = 0; i < 8; i++) sw[63-8*i -: 8] = blk_ctr[8*i +: 8];
				ks = encrypt({chain[0], sw});
				blk_ctr++;
				if (cnt > 16) cnt = 16;
				e.nbytes = cnt[4:0];
				ch = (ks[127:64] ^ ph) & lead_bytes(cnt);
				cl = (ks[63:0] ^ pl) & lead_bytes(cnt - 8);
			end
		endcase
		e.hi = ch; e.lo = cl; e.hdr = 1'b0; e.rend = 1'b1; e.mend = last;
		pending_ct.push_back(e);
		if (last) msg_open = 1'b0;
	endtask

	// Register write, only while the block is idle
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		wait (pending_ct.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 3'b000}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_MODE:      reg_mode = val[2:0];
			REG_KEY_WORDS: reg_key_words = val[3:0];
			REG_KEY_0:     reg_key[0] = val;
			REG_KEY_1:     reg_key[1] = val;
			REG_KEY_2:     reg_key[2] = val;
			REG_KEY_3:     reg_key[3] = val;
			REG_IV_HIGH:   reg_iv_high = val;
			default:       reg_iv_low = val;
		endcase
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic load_setup(input logic [2:0] m, input logic [3:0] kw);
		write_reg(REG_MODE, {61'h0, m});
		write_reg(REG_KEY_WORDS, {60'h0, kw});
		write_reg(REG_KEY_0, rand64());
		write_reg(REG_KEY_1, rand64());
		write_reg(REG_KEY_2, rand64());
		write_reg(REG_KEY_3, rand64());
		write_reg(REG_IV_HIGH, rand64());
		write_reg(REG_IV_LOW, rand64());
	endtask

	// Send one plaintext transaction, at times with a random gap before it
	task automatic send_block(input logic [63:0] ph, input logic [63:0] pl,
			input logic [4:0] cnt, input logic last);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		block_high <= ph; block_low <= pl; byte_count <= cnt; message_last <= last;
		do @(posedge clk); while (in_stall);
		predict_cipher(ph, pl, cnt, last);
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		// all-zero key and block, then an all-ones block, in ECB with AES-128
		send_block(64'h0, 64'h0, 5'd16, 1'b1);
		send_block('1, '1, 5'd31, 1'b1);
		end_burst();
		// modes CBC to CTR, each at one key length, two-block messages
		for (int m = MODE_CBC; m <= MODE_CTR; m++) begin
			load_setup(m[2:0], (m == MODE_CFB) ? 4'd6 : (m == MODE_OFB) ? 4'd8 : 4'd15);
			send_block(rand64(), rand64(), 5'd16, 1'b0);
			send_block(rand64(), rand64(), 5'd0, 1'b1);
			end_burst();
		end
		// partial counter blocks: empty, short, half, just over half, over-long
		write_reg(REG_KEY_WORDS, 64'd0);
		send_block(rand64(), rand64(), 5'd0, 1'b0);
		send_block(rand64(), rand64(), 5'd1, 1'b0);
		send_block(rand64(), rand64(), 5'd8, 1'b0);
		send_block(rand64(), rand64(), 5'd9, 1'b0);
		send_block(rand64(), rand64(), 5'd17, 1'b1);
		end_burst();
		// invalid mode gives nothing
		write_reg(REG_MODE, {61'h0, 3'd7});
		send_block(rand64(), rand64(), 5'd16, 1'b0);
		send_block(rand64(), rand64(), 5'd16, 1'b1);
		end_burst();
		// mode switch in the middle of a message
		write_reg(REG_MODE, {61'h0, MODE_CBC});
		send_block(rand64(), rand64(), 5'd16, 1'b0);
		end_burst();
		write_reg(REG_MODE, {61'h0, MODE_OFB});
		send_block(rand64(), rand64(), 5'd16, 1'b0);
		end_burst();
		write_reg(REG_MODE, {61'h0, MODE_CTR});
		send_block(rand64(), rand64(), 5'd5, 1'b1);
		end_burst();
	endtask

	task automatic test_random(input int items);
		int sent, len, m;
		logic [4:0] cnt;
		sent = 0;
		while (sent < items) begin
			m = ($urandom_range(19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
			load_setup(m[2:0], 4'($urandom_range(0, 15)));
			// mostly short messages so key setup is exercised often
			len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
			for (int i = 0; i < len; i++) begin
				cnt = ($urandom_range(3) == 0) ? 5'($urandom_range(0, 31)) : 5'd16;
				send_block(rand64(), rand64(), cnt, i == len - 1);
				if (m <= MODE_CTR) sent++;
			end
			end_burst();
		end
	endtask

	// Receiver holds off while the sender keeps going
	task automatic test_back_pressure();
		load_setup(MODE_CBC, 4'd8);
		hold_reqs++;
		for (int i = 0; i < 12; i++) send_block(rand64(), rand64(), 5'd16, i == 11);
		end_burst();
	endtask

	task automatic test_no_idle();
		idle_pct = 0;
		test_random(150);
		idle_pct = 17;
	endtask

	// Receiver stall, with its own count of a long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 0;
		end else if (hold_done != hold_reqs) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			hold_done <= hold_reqs;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// Result check
	always @(posedge clk) begin
		ct_block_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_ct.size() == 0) begin
				$display("%0t: unexpected result %h %h", $time, out_high, out_low);
				fail_cnt++;
			end else begin
				e = pending_ct.pop_front();
				if (out_high !== e.hi || out_low !== e.lo || out_bytes !== e.nbytes ||
						is_iv_header !== e.hdr || run_end !== e.rend ||
						message_end !== e.mend) begin
					$display("%0t: mismatch expected %h %h bytes %0d hdr %b re %b me %b",
						$time, e.hi, e.lo, e.nbytes, e.hdr, e.rend, e.mend);
					$display("%0t:          actual   %h %h bytes %0d hdr %b re %b me %b",
						$time, out_high, out_low, out_bytes, is_iv_header, run_end,
						message_end);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog on cycles with no transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; block_high = '0; block_low = '0; byte_count = '0;
		message_last = 1'b0;
		idle_pct = 17; hold_reqs = 0;
		reg_mode = MODE_ECB; reg_key_words = 4'd4;
		for (int i = 0; i < 4; i++) reg_key[i] = '0;
		reg_iv_high = '0; reg_iv_low = '0;
		chain[0] = '0; chain[1] = '0; blk_ctr = '0; msg_open = 1'b0; n_rounds = 10;
		for (int i = 0; i < 60; i++) sched[i] = '0;
		build_sub_tab();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_back_pressure();
		test_no_idle();
		test_random(1050);

		wait (pending_ct.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
